// File: rtl/clip_playback_mixer_unit_defines.svh
// ----------------------------------------------------------------------------
// Clip playback mixer assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CLIP_PLAYBACK_MIXER_UNIT_DEFINES_SVH
`define CLIP_PLAYBACK_MIXER_UNIT_DEFINES_SVH

// General property check.
`define CPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Hold check: whenever cond is seen, sig keeps its value into the next cycle.
`define CPM_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// Clip playback mixer package
// Sizes, register codes and the configuration bundle shared by the modules.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int unsigned SrcDepth    = 65536;
  localparam int unsigned SrcAddrW    = $clog2(SrcDepth);
  localparam int unsigned LenW        = SrcAddrW + 1;
  localparam int unsigned SineIdxW    = 10;
  localparam int unsigned SineStages  = 6;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned GainProdW   = 30;
  localparam int unsigned InDataW     = 128;
  localparam int unsigned OutDataW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegClipStart,
    RegClipEnd,
    RegSourceLength,
    RegSourceStep,
    RegPhaseStep,
    RegGain,
    RegPan
  } cfg_reg_e;

  // Configuration as seen by the datapath, including derived terms.
  typedef struct packed {
    logic [31:0]           clip_start;
    logic [31:0]           clip_end;
    logic [31:0]           source_step;
    logic [31:0]           phase_step;
    logic [LenW-1:0]       len;
    logic                  use_sine;
    logic [GainProdW-1:0]  gain_l;
    logic [GainProdW-1:0]  gain_r;
  } cfg_t;

endpackage

// File: rtl/clip_playback_mixer_unit.sv
// ----------------------------------------------------------------------------
// Clip playback mixer unit
// Adds one clip's panned, gained contribution to a streaming stereo mix.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser selects the word kind (0 load, 1 render). A load word
//   writes one stereo pair into the clip memory and returns nothing. A render
//   word carries a timeline position and the incoming mix; each returns one
//   master word with the saturated mix and the window flag in tuser.
//   Config channel: seven registers by index, written while the unit is idle.
//   Throughput: one word per cycle when nothing stalls. A render word passes
//   through every stage before it shows on the master side. The eleven-stage
//   pipeline is set by the 32x32 index product, one memory read stage, and
//   five dependent polynomial multiplies for the sine fallback.
//   Stall: each stage holds while the stage after it is full and blocked, so
//   empty stages keep taking words while a result waits on the master side.
//   Reset: registers go to their defaults, the pipeline empties. The clip
//   memory is not cleared; read only entries that were loaded.
// ----------------------------------------------------------------------------
`include "clip_playback_mixer_unit_defines.svh"

module clip_playback_mixer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // load_index, load_left, load_right, sample_position, mix_left_in, mix_right_in
  input  logic [cpm_pkg::InDataW-1:0]   s_axis_tdata,
  // operation
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mix_left_out, mix_right_out
  output logic [cpm_pkg::OutDataW-1:0]  m_axis_tdata,
  // clip_active
  output logic [0:0]                    m_axis_tuser,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cpm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cpm_pkg::*;

  localparam int unsigned StA = 1;
  localparam int unsigned StB = 2;
  localparam int unsigned StC = 3;
  localparam int unsigned StD = 4;
  localparam int unsigned StE = 5;
  localparam int unsigned StI = 9;
  localparam int unsigned StJ = 10;
  localparam int unsigned StK = 11;

  localparam logic OpRender = 1'b1;

  localparam int unsigned ProdW    = 16 + GainProdW + 1;
  localparam int unsigned RndW     = ProdW + 1;
  localparam int unsigned RndShift = 20;
  localparam int unsigned SumW     = 29;
  localparam logic signed [RndW-1:0] RndBias = RndW'(32'sd524288);
  localparam logic signed [23:0]     MixMax  = 24'sh7FFFFF;
  localparam logic signed [23:0]     MixMin  = 24'sh800000;

  function automatic logic signed [23:0] mix_add(input logic signed [23:0]    mix,
                                                 input logic signed [ProdW-1:0] prod);
    logic signed [RndW-1:0]        rnd;
    logic signed [RndW-RndShift-1:0] contrib;
    logic signed [SumW-1:0]        sum;
    rnd     = RndW'(prod) + RndBias;
    contrib = $signed(rnd[RndW-1:RndShift]);
    sum     = SumW'(mix) + SumW'(contrib);
    if (sum > SumW'(MixMax)) return MixMax;
    if (sum < SumW'(MixMin)) return MixMin;
    return sum[23:0];
  endfunction

  cfg_t cfg;

  cpm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Payload
  logic                     render_q [StA:StC];
  logic [15:0]              lidx_q   [StA:StC];
  logic [31:0]              ldata_q  [StA:StC];
  logic signed [23:0]       mixl_q   [StA:StJ];
  logic signed [23:0]       mixr_q   [StA:StJ];
  logic                     act_q    [StB:StJ];
  logic [31:0]              pos_q;
  logic [31:0]              offset_q;
  logic [63:0]              idx_prod;
  logic [31:0]              phase;
  logic [47:0]              idx_q;
  logic [SineIdxW-1:0]      sidx_q;
  logic [SrcAddrW-1:0]      rd_addr, wr_addr;
  logic                     wr_ok;
  logic [31:0]              rd_q;
  logic [31:0]              src_q    [StE:StI];
  logic signed [15:0]       sine_y;
  logic signed [15:0]       samp_l, samp_r;
  logic signed [ProdW-1:0]  prod_l_d, prod_r_d, prod_l_q, prod_r_q;
  logic signed [23:0]       out_l_q, out_r_q;
  logic                     out_act_q;

  // Stage control
  logic [StK:StA]   valid_q;
  logic [StK:StA]   vin;
  logic [StK:StA]   en;

  for (genvar k = StA; k <= StK; k++) begin : g_en
    assign en[k] = m_axis_tready | ~(&valid_q[StK:k]);
  end

  always_comb begin
    vin[StA] = s_axis_tvalid;
    for (int k = StB; k <= StK; k++) vin[k] = valid_q[k-1];
    // drop load words once they have written the memory
    vin[StD] = valid_q[StC] & render_q[StC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = StA; k <= StK; k++) begin
        if (en[k]) valid_q[k] <= vin[k];
      end
    end
  end

  assign s_axis_tready = en[StA];

  assign idx_prod = 64'(offset_q) * 64'(cfg.source_step);
  assign phase    = offset_q * cfg.phase_step;

  always_ff @(posedge clk_i) begin
    if (en[StA]) begin
      render_q[StA] <= (s_axis_tuser[0] == OpRender);
      lidx_q[StA]   <= s_axis_tdata[15:0];
      ldata_q[StA]  <= s_axis_tdata[47:16];
      pos_q         <= s_axis_tdata[79:48];
      mixl_q[StA]   <= $signed(s_axis_tdata[103:80]);
      mixr_q[StA]   <= $signed(s_axis_tdata[127:104]);
    end
    for (int k = StB; k <= StC; k++) begin
      if (en[k]) begin
        render_q[k] <= render_q[k-1];
        lidx_q[k]   <= lidx_q[k-1];
        ldata_q[k]  <= ldata_q[k-1];
      end
    end
    for (int k = StB; k <= StJ; k++) begin
      if (en[k]) begin
        mixl_q[k] <= mixl_q[k-1];
        mixr_q[k] <= mixr_q[k-1];
      end
    end
    if (en[StB]) begin
      offset_q    <= pos_q - cfg.clip_start;
      act_q[StB]  <= (pos_q >= cfg.clip_start) && (pos_q < cfg.clip_end);
    end
    for (int k = StC; k <= StJ; k++) begin
      if (en[k]) act_q[k] <= act_q[k-1];
    end
    if (en[StC]) begin
      idx_q  <= idx_prod[63:16];
      sidx_q <= phase[31 -: SineIdxW];
    end
    if (en[StE]) src_q[StE] <= rd_q;
    for (int k = StE + 1; k <= StI; k++) begin
      if (en[k]) src_q[k] <= src_q[k-1];
    end
    if (en[StJ]) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    if (en[StK]) begin
      out_act_q <= act_q[StJ];
      out_l_q   <= act_q[StJ] ? mix_add(mixl_q[StJ], prod_l_q) : mixl_q[StJ];
      out_r_q   <= act_q[StJ] ? mix_add(mixr_q[StJ], prod_r_q) : mixr_q[StJ];
    end
  end

  // Clip memory: loads and reads both happen on the move into stage D,
  // so every read sees exactly the loads that came before it.
  logic [31:0] src_mem [SrcDepth];

  assign rd_addr = (idx_q >= 48'(cfg.len)) ? SrcAddrW'(cfg.len - LenW'(1))
                                           : SrcAddrW'(idx_q);
  assign wr_addr = SrcAddrW'(lidx_q[StC]);
  assign wr_ok   = 32'(lidx_q[StC]) < 32'(SrcDepth);

  always_ff @(posedge clk_i) begin
    if (en[StD] && valid_q[StC]) begin
      if (render_q[StC]) begin
        rd_q <= src_mem[rd_addr];
      end else if (wr_ok) begin
        src_mem[wr_addr] <= ldata_q[StC];
      end
    end
  end

  cpm_sine_pipe u_sine (
    .clk_i  (clk_i),
    .en_i   (en[StI:StD]),
    .idx_i  (sidx_q),
    .sine_o (sine_y)
  );

  assign samp_l   = cfg.use_sine ? sine_y : $signed(src_q[StI][15:0]);
  assign samp_r   = cfg.use_sine ? sine_y : $signed(src_q[StI][31:16]);
  assign prod_l_d = ProdW'(samp_l) * ProdW'($signed({1'b0, cfg.gain_l}));
  assign prod_r_d = ProdW'(samp_r) * ProdW'($signed({1'b0, cfg.gain_r}));

  assign m_axis_tvalid = valid_q[StK];
  assign m_axis_tdata  = {out_r_q, out_l_q};
  assign m_axis_tuser  = out_act_q;

  `CPM_ASSERT(a_ready_when_drained, !valid_q[StK] |-> s_axis_tready, "input blocked with empty output stage")
  `CPM_ASSERT(a_load_no_result, valid_q[StC] && !render_q[StC] && en[StD] |=> !valid_q[StD], "load word passed the memory stage")
  `CPM_ASSERT(a_stall_keeps_word, valid_q[StK] && !m_axis_tready && valid_q[StJ] |=> valid_q[StJ] && valid_q[StK], "stalled stage lost a word")
  `CPM_ASSERT_HOLD(a_stall_keeps_prod, valid_q[StK] && !m_axis_tready && valid_q[StJ] && act_q[StJ], prod_l_q, "stalled product changed")
  `CPM_ASSERT(a_read_in_range, valid_q[StC] && render_q[StC] && !cfg.use_sine |-> 32'(rd_addr) < 32'(cfg.len), "clip read past source length")

endmodule

// File: rtl/cpm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Clip playback mixer configuration registers
// Register file plus derived terms: clamped length, pan factors, gain products.
// ----------------------------------------------------------------------------
module cpm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cpm_pkg::CfgDataW-1:0]  cfg_data_i,
  output cpm_pkg::cfg_t                 cfg_o
);
  import cpm_pkg::*;

  localparam logic [14:0]          Unity      = 15'd16384;
  localparam logic [GainProdW-1:0] UnityGain  = GainProdW'(32'd268435456);

  logic [31:0]           clip_start_q, clip_end_q, source_step_q, phase_step_q;
  logic [16:0]           source_len_q;
  logic [15:0]           gain_q;
  logic signed [15:0]    pan_q;
  logic signed [15:0]    pan_c;
  logic [14:0]           lfac_d, lfac_q, rfac_d, rfac_q;
  logic [LenW-1:0]       len_d, len_q;
  logic [GainProdW-1:0]  gain_l_d, gain_l_q, gain_r_d, gain_r_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_start_q  <= '0;
      clip_end_q    <= '0;
      source_len_q  <= '0;
      source_step_q <= 32'd65536;
      phase_step_q  <= '0;
      gain_q        <= 16'd16384;
      pan_q         <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegClipStart:    clip_start_q  <= cfg_data_i;
        RegClipEnd:      clip_end_q    <= cfg_data_i;
        RegSourceLength: source_len_q  <= cfg_data_i[16:0];
        RegSourceStep:   source_step_q <= cfg_data_i;
        RegPhaseStep:    phase_step_q  <= cfg_data_i;
        RegGain:         gain_q        <= cfg_data_i[15:0];
        RegPan:          pan_q         <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // Linear pan law on the clamped pan value, and the clamped source length.
  always_comb begin
    pan_c = pan_q;
    if (pan_q > 16'sd16384) pan_c = 16'sd16384;
    if (pan_q < -16'sd16384) pan_c = -16'sd16384;
    lfac_d = (pan_c <= 16'sd0) ? Unity : 15'(16'sd16384 - pan_c);
    rfac_d = (pan_c >= 16'sd0) ? Unity : 15'(16'sd16384 + pan_c);
    len_d  = (32'(source_len_q) > 32'(SrcDepth)) ? LenW'(SrcDepth) : LenW'(source_len_q);
  end

  assign gain_l_d = GainProdW'(gain_q) * GainProdW'(lfac_q);
  assign gain_r_d = GainProdW'(gain_q) * GainProdW'(rfac_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfac_q   <= Unity;
      rfac_q   <= Unity;
      len_q    <= '0;
      gain_l_q <= UnityGain;
      gain_r_q <= UnityGain;
    end else begin
      lfac_q   <= lfac_d;
      rfac_q   <= rfac_d;
      len_q    <= len_d;
      gain_l_q <= gain_l_d;
      gain_r_q <= gain_r_d;
    end
  end

  assign cfg_o.clip_start  = clip_start_q;
  assign cfg_o.clip_end    = clip_end_q;
  assign cfg_o.source_step = source_step_q;
  assign cfg_o.phase_step  = phase_step_q;
  assign cfg_o.len         = len_q;
  assign cfg_o.use_sine    = (len_q == '0);
  assign cfg_o.gain_l      = gain_l_q;
  assign cfg_o.gain_r      = gain_r_q;

endmodule

// File: rtl/cpm_sine_pipe.sv
// ----------------------------------------------------------------------------
// Clip playback mixer sine pipeline
// Q15 sine from a table index: quarter-wave fold and a 7th-order odd
// polynomial, one multiply per stage after the fold stage, six stages.
// ----------------------------------------------------------------------------
module cpm_sine_pipe (
  input  logic                               clk_i,
  input  logic [cpm_pkg::SineStages-1:0]     en_i,
  input  logic [cpm_pkg::SineIdxW-1:0]       idx_i,
  output logic signed [15:0]                 sine_o
);
  import cpm_pkg::*;

  localparam int unsigned QuadW = SineIdxW - 2;

  logic [16:0]        u_d;
  logic [16:0]        u_q   [0:4];
  logic               neg_q [0:4];
  logic [16:0]        u2_q  [1:3];
  logic [16:0]        s1_q, s2_q, s3_q;
  logic [33:0]        p_u2, p_s1, p_s2, p_s3, p_y;
  logic [16:0]        y_raw;
  logic [14:0]        y_cap;
  logic signed [15:0] y_q;

  always_comb begin
    u_d = 17'(idx_i[QuadW-1:0]) << (16 - QuadW);
    if (idx_i[QuadW]) u_d = 17'd65536 - u_d;
  end

  assign p_u2  = 34'(u_q[0]) * 34'(u_q[0]);
  assign p_s1  = 34'(u2_q[1]) * 34'd307;
  assign p_s2  = 34'(u2_q[2]) * 34'(s1_q);
  assign p_s3  = 34'(u2_q[3]) * 34'(s2_q);
  assign p_y   = 34'(u_q[4]) * 34'(s3_q);
  assign y_raw = p_y[33:17];
  assign y_cap = (y_raw > 17'd32767) ? 15'h7FFF : y_raw[14:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[0]   <= u_d;
      neg_q[0] <= idx_i[SineIdxW-1];
    end
    for (int k = 1; k <= 4; k++) begin
      if (en_i[k]) begin
        u_q[k]   <= u_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
    if (en_i[1]) u2_q[1] <= p_u2[32:16];
    if (en_i[2]) begin
      u2_q[2] <= u2_q[1];
      s1_q    <= 17'd5223 - p_s1[32:16];
    end
    if (en_i[3]) begin
      u2_q[3] <= u2_q[2];
      s2_q    <= 17'd42334 - p_s2[32:16];
    end
    if (en_i[4]) s3_q <= 17'd102944 - p_s3[32:16];
    if (en_i[5]) y_q <= neg_q[4] ? -$signed({1'b0, y_cap}) : $signed({1'b0, y_cap});
  end

  assign sine_o = y_q;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Clip playback mixer unit testbench
// Drives load and render words through the slave stream with random gaps and
// stalls the master stream at random, with one long hold-off. Render words are
// predicted on acceptance from local copies of the clip memory and registers,
// or carry a fixed expectation; every returned word is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cpm_pkg::*;

  localparam logic                OpLoad        = 1'b0;
  localparam logic                OpRender      = 1'b1;
  localparam logic [CfgIdxW-1:0]  RegBeyondList = 3'd7;
  localparam int                  DrainCycles   = 20;
  localparam int                  HoldCycles    = 300;
  localparam int                  Phases        = 8;
  localparam int                  PhaseWords    = 80;
  localparam int                  PreloadWords  = 64;
  localparam int unsigned         CycleLimit    = 400000;

  typedef enum logic [1:0] {RowCfg, RowLoad, RowRender} row_kind_e;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic        active;
  } mix_result_t;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [31:0]         reg_val;
    logic [InDataW-1:0]  word;
    logic                typed;
    mix_result_t         want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // Local copy of the register set and clip memory.
  logic [31:0]          win_start, win_end, step_src, step_phase;
  logic [LenW-1:0]      src_len;
  int                   clip_gain;
  logic signed [15:0]   pan_reg;
  logic [15:0]          src_left_mem [SrcDepth];
  logic [15:0]          src_right_mem [SrcDepth];
  bit                   src_loaded [SrcDepth];

  mix_result_t          mix_pending [$];
  int                   errors = 0;
  int unsigned          cycles = 0;
  bit                   tx_idle = 1'b0;
  bit                   rx_idle = 1'b0;
  bit                   hold_on = 1'b0;

  always #1 clk_i = ~clk_i;

  clip_playback_mixer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    case (idx)
      RegClipStart:    win_start  = val;
      RegClipEnd:      win_end    = val;
      RegSourceLength: src_len    = val[LenW-1:0];
      RegSourceStep:   step_src   = val;
      RegPhaseStep:    step_phase = val;
      RegGain:         clip_gain  = int'(val[15:0]);
      RegPan:          pan_reg    = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic bit in_window(logic [31:0] pos);
    return pos >= win_start && pos < win_end;
  endfunction

  // Stretched read address, clamped to the last sample within the source length.
  function automatic logic [63:0] source_index(logic [31:0] offset);
    logic [63:0] idx;
    logic [63:0] eff_len;
    idx = ({32'b0, offset} * {32'b0, step_src}) >> 16;
    eff_len = (src_len > SrcDepth) ? 64'(SrcDepth) : 64'(src_len);
    if (idx > eff_len - 1) idx = eff_len - 1;
    return idx;
  endfunction

  // Quarter-wave sine from an odd polynomial, Q15 out.
  function automatic int sine_value(logic [SineIdxW-1:0] idx);
    logic [1:0]  quad;
    logic [63:0] u, u2, s, y;
    quad = idx[SineIdxW-1 -: 2];
    u = 64'(idx[SineIdxW-3:0]) << (16 - (SineIdxW - 2));
    if (quad[0]) u = 64'd65536 - u;
    u2 = (u * u) >> 16;
    s = 64'd5223 - ((u2 * 64'd307) >> 16);
    s = 64'd42334 - ((u2 * s) >> 16);
    s = 64'd102944 - ((u2 * s) >> 16);
    y = ((u * s) >> 16) >> 1;
    if (y > 64'd32767) y = 64'd32767;
    return quad[1] ? -int'(y) : int'(y);
  endfunction

  function automatic logic [23:0] mix_sum(logic signed [23:0] mix, int s, int factor);
    longint p, v;
    p = longint'(s) * longint'(clip_gain) * longint'(factor);
    v = longint'(mix) + ((p + (64'sd1 <<< 19)) >>> 20);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  function automatic mix_result_t mix_predict(logic [InDataW-1:0] w);
    logic [31:0] pos, offset, phase;
    logic [23:0] ml, mr;
    logic [63:0] idx;
    int          sl, sr, p, lf, rf;
    mix_result_t res;
    pos = w[79:48];
    ml  = w[103:80];
    mr  = w[127:104];
    if (!in_window(pos)) begin
      res.left   = ml;
      res.right  = mr;
      res.active = 1'b0;
      return res;
    end
    offset = pos - win_start;
    if (src_len != 0) begin
      idx = source_index(offset);
      sl  = int'($signed(src_left_mem[idx[15:0]]));
      sr  = int'($signed(src_right_mem[idx[15:0]]));
    end else begin
      phase = offset * step_phase;
      sl = sine_value(phase[31 -: SineIdxW]);
      sr = sl;
    end
    p = int'(pan_reg);
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    lf = (p <= 0) ? 16384 : 16384 - p;
    rf = (p >= 0) ? 16384 : 16384 + p;
    res.left   = mix_sum(ml, sl, lf);
    res.right  = mix_sum(mr, sr, rf);
    res.active = 1'b1;
    return res;
  endfunction

  // True when a render at pos touches no clip memory entry that was not loaded.
  function automatic bit read_is_loaded(logic [31:0] pos);
    logic [63:0] idx;
    if (!in_window(pos) || src_len == 0) return 1'b1;
    idx = source_index(pos - win_start);
    return src_loaded[idx[15:0]];
  endfunction

  // ------------------------------------------------------------------ stimulus

  function automatic logic [InDataW-1:0] make_word(logic [15:0] a, logic [15:0] l,
      logic [15:0] r, logic [31:0] pos, logic [23:0] ml, logic [23:0] mr);
    return {mr, ml, pos, r, l, a};
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    stim_row_t row;
    row = '0;
    row.kind    = RowCfg;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic stim_row_t load_row(logic [15:0] a, logic [15:0] l, logic [15:0] r);
    stim_row_t row;
    row = '0;
    row.kind = RowLoad;
    row.word = make_word(a, l, r, 32'd0, 24'd0, 24'd0);
    return row;
  endfunction

  function automatic stim_row_t render_row(logic [31:0] pos, logic [23:0] ml,
      logic [23:0] mr);
    stim_row_t row;
    row = '0;
    row.kind = RowRender;
    row.word = make_word(16'd0, 16'd0, 16'd0, pos, ml, mr);
    return row;
  endfunction

  function automatic stim_row_t render_want(logic [31:0] pos, logic [23:0] ml,
      logic [23:0] mr, logic [23:0] el, logic [23:0] er, logic ea);
    stim_row_t row;
    row = render_row(pos, ml, mr);
    row.typed = 1'b1;
    row.want  = '{left: el, right: er, active: ea};
    return row;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [23:0] pick_mix();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    return 24'($urandom);
  endfunction

  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return win_start + $urandom_range(0, 300);
    if (r < 70 && win_end > win_start) return win_start + $urandom_range(0, win_end - win_start - 1);
    return $urandom;
  endfunction

  // Offer one word, hold it until taken, then predict a render or record a load.
  task automatic push_word(input logic op, input logic [InDataW-1:0] word, input logic typed,
      input mix_result_t want);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = word;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (op == OpRender) begin
      mix_pending.push_back(typed ? want : mix_predict(word));
    end else begin
      src_left_mem[word[15:0]]  = word[31:16];
      src_right_mem[word[15:0]] = word[47:32];
      src_loaded[word[15:0]]    = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop valid, wait for every result, then let loads clear the pipeline.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (mix_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_load(input logic [15:0] addr);
    push_word(OpLoad, make_word(addr, 16'($urandom), 16'($urandom), $urandom, 24'($urandom),
              24'($urandom)), 1'b0, '0);
  endtask

  task automatic random_render();
    logic [31:0] pos;
    pos = pick_position();
    for (int tries = 0; tries < 16 && !read_is_loaded(pos); tries++) pos = pick_position();
    // offset zero always reads entry zero, which is loaded
    if (!read_is_loaded(pos)) pos = win_start;
    push_word(OpRender, make_word(16'($urandom), 16'($urandom), 16'($urandom), pos,
              pick_mix(), pick_mix()), 1'b0, '0);
  endtask

  task automatic random_regs();
    logic [31:0] start, stop, val;
    int          r;
    r = $urandom_range(0, 3);
    start = (r == 0) ? 32'd0 : (r == 1) ? $urandom :
            (r == 2) ? 32'hFFFF_F000 + $urandom_range(0, 255) : $urandom_range(0, 1000);
    r = $urandom_range(0, 19);
    stop = (r == 0) ? start : (r < 3) ? $urandom : start + $urandom_range(1, 4000);
    write_reg(RegClipStart, start);
    write_reg(RegClipEnd, stop);
    r = $urandom_range(0, 19);
    val = (r < 6) ? 32'd0 : (r < 12) ? $urandom_range(1, PreloadWords) :
          (r < 14) ? 32'(SrcDepth) : (r < 17) ? $urandom_range(65, 1000) : $urandom;
    write_reg(RegSourceLength, val);
    r = $urandom_range(0, 3);
    val = (r == 0) ? $urandom : (r == 1) ? 32'h0001_0000 : $urandom_range(0, 4 * 65536);
    write_reg(RegSourceStep, val);
    write_reg(RegPhaseStep, $urandom);
    r = $urandom_range(0, 9);
    val = (r == 0) ? 32'h0000_FFFF : (r == 1) ? 32'd16384 : $urandom;
    write_reg(RegGain, val);
    r = $urandom_range(0, 9);
    val = (r == 0) ? $urandom : 32'($urandom_range(0, 32768)) - 32'd16384;
    write_reg(RegPan, val);
    if ($urandom_range(0, 3) == 0) write_reg(RegBeyondList, $urandom);
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    stim_row_t rows [$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpLoad;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegClipStart;
    cfg_data_i    = '0;
    win_start  = 32'd0;
    win_end    = 32'd0;
    src_len    = '0;
    step_src   = 32'h0001_0000;
    step_phase = 32'd0;
    clip_gain  = 16384;
    pan_reg    = 16'sd0;

    // After reset the window is empty: everything passes through.
    rows.push_back(render_want(32'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0));
    rows.push_back(render_want(32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000,
                               24'h7FFFFF, 24'h800000, 1'b0));
    rows.push_back(load_row(16'd0, 16'h7FFF, 16'h8000));
    rows.push_back(load_row(16'd1, 16'h8000, 16'h7FFF));
    rows.push_back(load_row(16'd2, 16'h5555, 16'hAAAA));
    rows.push_back(load_row(16'd3, 16'hAAAA, 16'h5555));
    rows.push_back(load_row(16'hFFFF, 16'h04D2, 16'hFB2E));
    // Sine fallback at zero phase adds nothing; window start is inclusive, end exclusive.
    rows.push_back(cfg_row(RegClipStart, 32'd100));
    rows.push_back(cfg_row(RegClipEnd, 32'd200));
    rows.push_back(render_want(32'd100, 24'd5, 24'hFFFFFB, 24'd5, 24'hFFFFFB, 1'b1));
    rows.push_back(render_want(32'd99, 24'h123456, 24'hFEDCBA, 24'h123456, 24'hFEDCBA, 1'b0));
    rows.push_back(render_want(32'd200, 24'h000100, 24'hFFFF00, 24'h000100, 24'hFFFF00, 1'b0));
    rows.push_back(render_row(32'd199, 24'h000100, 24'hFFFF00));
    // Quarter-circle step walks the sine through its peaks and zero.
    rows.push_back(cfg_row(RegPhaseStep, 32'h4000_0000));
    rows.push_back(render_row(32'd101, 24'd0, 24'd0));
    rows.push_back(render_row(32'd102, 24'd0, 24'd0));
    rows.push_back(render_row(32'd103, 24'h7FFF00, 24'h800100));
    // Full gain, hard left: left saturates, right gets nothing.
    rows.push_back(cfg_row(RegSourceLength, 32'd4));
    rows.push_back(cfg_row(RegGain, 32'h0000_FFFF));
    rows.push_back(cfg_row(RegPan, 32'h0000_C000));
    rows.push_back(render_want(32'd100, 24'h7FFFFF, 24'd0, 24'h7FFFFF, 24'd0, 1'b1));
    rows.push_back(render_want(32'd101, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1));
    rows.push_back(render_row(32'd150, 24'd0, 24'd0));
    // Pan past full right, length beyond the memory, largest stretch step.
    rows.push_back(cfg_row(RegPan, 32'h0000_7FFF));
    rows.push_back(cfg_row(RegSourceLength, 32'h0001_FFFF));
    rows.push_back(cfg_row(RegSourceStep, 32'hFFFF_FFFF));
    rows.push_back(render_row(32'd100, 24'd1, 24'hFFFFFF));
    rows.push_back(render_row(32'd101, 24'd0, 24'd0));
    rows.push_back(cfg_row(RegPan, 32'h0000_8000));
    rows.push_back(render_row(32'd102, 24'h400000, 24'hC00000));
    // Empty windows: start equal to end, and end below start.
    rows.push_back(cfg_row(RegClipStart, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(RegClipEnd, 32'hFFFF_FFFF));
    rows.push_back(render_want(32'hFFFF_FFFF, 24'd1, 24'd2, 24'd1, 24'd2, 1'b0));
    rows.push_back(cfg_row(RegClipStart, 32'd5));
    rows.push_back(cfg_row(RegClipEnd, 32'd3));
    rows.push_back(render_want(32'd4, 24'h00ABCD, 24'hFF0000, 24'h00ABCD, 24'hFF0000, 1'b0));
    // Zero gain adds nothing anywhere in the widest window.
    rows.push_back(cfg_row(RegClipStart, 32'd0));
    rows.push_back(cfg_row(RegClipEnd, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(RegSourceLength, 32'd0));
    rows.push_back(cfg_row(RegPhaseStep, 32'h1234_5679));
    rows.push_back(cfg_row(RegGain, 32'd0));
    rows.push_back(render_want(32'hFFFF_FFFE, 24'd77, 24'hFFFFB3, 24'd77, 24'hFFFFB3, 1'b1));
    rows.push_back(cfg_row(RegGain, 32'd16384));
    rows.push_back(cfg_row(RegPan, 32'd0));
    rows.push_back(cfg_row(RegSourceStep, 32'd0));
    rows.push_back(cfg_row(RegSourceLength, 32'(SrcDepth)));
    rows.push_back(cfg_row(RegBeyondList, 32'hDEAD_BEEF));
    rows.push_back(render_row(32'h8000_0000, 24'd0, 24'd0));
    rows.push_back(render_row(32'hABCD_1234, 24'h3FFFFF, 24'hC00001));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      case (rows[i].kind)
        RowCfg: begin
          settle();
          write_reg(rows[i].reg_idx, rows[i].reg_val);
        end
        RowLoad:   push_word(OpLoad, rows[i].word, 1'b0, '0);
        default:   push_word(OpRender, rows[i].word, rows[i].typed, rows[i].want);
      endcase
    end

    tx_idle = 1'b1;
    for (int a = 0; a < PreloadWords; a++) random_load(16'(a));

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      random_regs();
      tx_idle = (ph % 4 == 1) || (ph % 4 == 3);
      rx_idle = (ph % 4 == 2) || (ph % 4 == 3);
      // one phase with a long receiver hold-off and a busy sender
      if (ph == 2) begin
        tx_idle = 1'b0;
        hold_on = 1'b1;
      end
      for (int n = 0; n < PhaseWords; n++) begin
        if ($urandom_range(0, 3) == 0)
          random_load(($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 255)) : 16'($urandom));
        else
          random_render();
      end
    end

    settle();
    if (errors == 0) begin
      $display("** clip_playback_mixer_unit: PASSED **");
    end else begin
      $display("** clip_playback_mixer_unit: FAILED **");
    end
    $finish;
  end

  // ----------------------------------------------------------------- receiver

  initial begin
    int stall_left;
    int held;
    bit hold_done;
    stall_left = 0;
    held = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_on && !hold_done) begin
        m_axis_tready = 1'b0;
        held++;
        if (held == HoldCycles) hold_done = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_idle) stall_left = pick_gap();
      end
    end
  end

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what, input logic [23:0] got,
      input logic [23:0] want);
    $display("mismatch at cycle %0d: %s: got %h, want %h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    mix_result_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (mix_pending.size() == 0) begin
        report_mismatch("word with nothing pending", m_axis_tdata[23:0], 24'd0);
      end else begin
        want = mix_pending.pop_front();
        if (m_axis_tdata[23:0] !== want.left)
          report_mismatch("mix_left_out", m_axis_tdata[23:0], want.left);
        if (m_axis_tdata[47:24] !== want.right)
          report_mismatch("mix_right_out", m_axis_tdata[47:24], want.right);
        if (m_axis_tuser[0] !== want.active)
          report_mismatch("clip_active", 24'(m_axis_tuser[0]), 24'(want.active));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, mix_pending.size());
      $display("** clip_playback_mixer_unit: FAILED **");
      $finish;
    end
  end

endmodule
